FILE: rtl/core/tmcr_pkg.sv
// shared constants, codes and control types of the text-mode console renderer
package tmcr_pkg;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 64;
  localparam int GLYPH_HEIGHT = 16;
  localparam int MAX_SCALE    = 4;

  localparam int CELLS      = MAX_COLS * MAX_ROWS;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CELL_AW    = COL_W + ROW_W;
  localparam int LINE_W     = $clog2(GLYPH_HEIGHT);
  localparam int GLYPH_AW   = 7 + LINE_W;
  localparam int GLYPH_ROWS = 1 << GLYPH_AW;
  localparam int CUR_W      = 14;

  localparam logic [2:0] CFG_COLS  = 3'd0;
  localparam logic [2:0] CFG_ROWS  = 3'd1;
  localparam logic [2:0] CFG_SCALE = 3'd2;

  localparam logic [1:0] FUNC_PUT    = 2'd0;
  localparam logic [1:0] FUNC_CELL   = 2'd1;
  localparam logic [1:0] FUNC_GLYPH  = 2'd2;
  localparam logic [1:0] FUNC_RENDER = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [31:0] RST_FG = 32'hffff_ffff;
  localparam logic [31:0] RST_BG = 32'h0000_0000;

  typedef enum logic [1:0] {
    DIV_RB,
    DIV_CUR,
    DIV_X,
    DIV_Y
  } div_op_e;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    save_rbm;
    logic    save_u;
    logic    save_v;
    logic    apply_lf;
    logic    do_scroll;
    logic    clr_write;
    logic    put_write;
    logic    cell_write;
    logic    glyph_write;
    logic    out_load;
    logic    init_write;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_cr;
    logic       is_lf;
    logic       div_done;
    logic       div_busy;
    logic       need_scroll;
    logic       clr_last;
    logic       init_last;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/core/tmcr_ram.sv
// generic simple dual-port ram with registered read
module tmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tmcr_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module tmcr_div import tmcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CUR_W-1:0] dividend_i,
  input  logic [7:0]       divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [CUR_W-1:0] quo_o,
  output logic [7:0]       rem_o
);

  localparam int CNT_W = $clog2(CUR_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CUR_W-1:0] quo_q;
  logic [7:0]       rem_q;
  logic [7:0]       dvs_q;
  logic [8:0]       shifted;
  logic [8:0]       diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[CUR_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(CUR_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[CUR_W-2:0], ge};
      rem_q <= ge ? diff[7:0] : shifted[7:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/tmcr_dp.sv
// datapath: geometry, cursor, ring base, stores, divider and result register
module tmcr_dp import tmcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  cell_col_i,
  input  logic [5:0]  cell_row_i,
  input  logic [31:0] fg_color_i,
  input  logic [31:0] bg_color_i,
  input  logic [7:0]  glyph_bits_i,
  input  logic [3:0]  glyph_line_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_color_o
);

  function automatic logic [ROW_W-1:0] ring_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] base,
                                                input logic [ROW_W:0]   n);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, base};
    if (sum >= n) begin
      sum = sum - n;
    end
    return sum[ROW_W-1:0];
  endfunction

  // configuration
  logic [7:0] cols_q;
  logic [6:0] rows_q;
  logic [2:0] scale_q;

  // item
  logic [1:0]  func_q;
  logic [7:0]  code_q;
  logic [6:0]  col_q;
  logic [5:0]  row_q;
  logic [31:0] fg_q;
  logic [31:0] bg_q;
  logic [7:0]  gbits_q;
  logic [3:0]  gline_q;
  logic [11:0] px_q;
  logic [11:0] py_q;

  // console state
  logic [CUR_W-1:0]   cursor_q;
  logic [ROW_W-1:0]   rb_q;
  logic [ROW_W-1:0]   rbm_q;
  logic [11:0]        u_q;
  logic [11:0]        v_q;
  logic [ROW_W-1:0]   clr_row_q;
  logic [COL_W-1:0]   clr_col_q;
  logic [CELL_AW-1:0] init_cnt_q;
  logic               out_valid_q;
  logic [31:0]        pixel_q;

  logic [7:0]       nc;
  logic [6:0]       nr;
  logic [2:0]       sc;
  logic [14:0]      size;
  logic [ROW_W-1:0] nr_m1;
  logic [6:0]       rb_inc;
  logic [ROW_W-1:0] new_rb;

  logic             div_busy;
  logic             div_done;
  logic [CUR_W-1:0] div_q;
  logic [7:0]       div_r;
  logic [CUR_W-1:0] dvd;
  logic [7:0]       dvs;

  logic [ROW_W-1:0] put_row;
  logic [ROW_W-1:0] cell_prow;
  logic             cell_ok;
  logic [8:0]       rc;
  logic [7:0]       rr;
  logic             in_grid;
  logic [ROW_W-1:0] rprow;
  logic [7:0]       gcode;
  logic             gbit;
  logic [31:0]      pix;
  logic             out_free;

  logic               ch_we;
  logic [CELL_AW-1:0] ch_waddr;
  logic [7:0]         ch_wdata;
  logic [7:0]         ch_rdata;
  logic               col_we;
  logic [CELL_AW-1:0] col_waddr;
  logic [31:0]        fg_wdata;
  logic [31:0]        bg_wdata;
  logic [31:0]        fg_rdata;
  logic [31:0]        bg_rdata;
  logic               gl_we;
  logic [7:0]         gl_rdata;

  always_comb begin
    nc = cols_q;
    if (cols_q == 8'd0) begin
      nc = 8'd1;
    end else if (cols_q > 8'(MAX_COLS)) begin
      nc = 8'(MAX_COLS);
    end
    nr = rows_q;
    if (rows_q == 7'd0) begin
      nr = 7'd1;
    end else if (rows_q > 7'(MAX_ROWS)) begin
      nr = 7'(MAX_ROWS);
    end
    sc = scale_q;
    if (scale_q == 3'd0) begin
      sc = 3'd1;
    end else if (scale_q > 3'(MAX_SCALE)) begin
      sc = 3'(MAX_SCALE);
    end
  end

  assign size   = {7'd0, nc} * {8'd0, nr};
  assign nr_m1  = ROW_W'(nr - 7'd1);
  assign rb_inc = {1'b0, rbm_q} + 7'd1;
  assign new_rb = (rb_inc == nr) ? '0 : rb_inc[ROW_W-1:0];

  // divider operand select
  always_comb begin
    case (cmd_i.div_op)
      DIV_RB: begin
        dvd = {{(CUR_W-ROW_W){1'b0}}, rb_q};
        dvs = {1'b0, nr};
      end
      DIV_CUR: begin
        dvd = cursor_q;
        dvs = nc;
      end
      DIV_X: begin
        dvd = {2'b0, px_q};
        dvs = {5'b0, sc};
      end
      DIV_Y: begin
        dvd = {2'b0, py_q};
        dvs = {5'b0, sc};
      end
      default: begin
        dvd = cursor_q;
        dvs = nc;
      end
    endcase
  end

  tmcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_q),
    .rem_o      (div_r)
  );

  assign put_row   = ring_row(div_q[ROW_W-1:0], rbm_q, nr);
  assign cell_prow = ring_row(row_q, rbm_q, nr);
  assign cell_ok   = ({1'b0, col_q} < nc) && ({1'b0, row_q} < nr);
  assign rc        = u_q[11:3];
  assign rr        = v_q[11:4];
  assign in_grid   = (rc < {1'b0, nc}) && (rr < {1'b0, nr});
  assign rprow     = ring_row(rr[ROW_W-1:0], rbm_q, nr);
  assign gcode     = ch_rdata[7] ? CH_QMARK : ch_rdata;
  assign gbit      = gl_rdata[~u_q[2:0]];
  assign pix       = in_grid ? (gbit ? fg_rdata : bg_rdata) : 32'd0;
  assign out_free  = !out_valid_q || !out_stall_i;

  // character store write select
  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = init_cnt_q;
    ch_wdata = CH_SPACE;
    if (cmd_i.init_write) begin
      ch_we = 1'b1;
    end else if (cmd_i.clr_write) begin
      ch_we    = 1'b1;
      ch_waddr = {clr_row_q, clr_col_q};
      ch_wdata = 8'd0;
    end else if (cmd_i.put_write) begin
      ch_we    = 1'b1;
      ch_waddr = {put_row, div_r[COL_W-1:0]};
      ch_wdata = code_q;
    end else if (cmd_i.cell_write && cell_ok) begin
      ch_we    = 1'b1;
      ch_waddr = {cell_prow, col_q};
      ch_wdata = code_q;
    end
  end

  assign col_we    = cmd_i.init_write || (cmd_i.cell_write && cell_ok);
  assign col_waddr = cmd_i.init_write ? init_cnt_q : {row_q, col_q};
  assign fg_wdata  = cmd_i.init_write ? RST_FG : fg_q;
  assign bg_wdata  = cmd_i.init_write ? RST_BG : bg_q;
  assign gl_we     = cmd_i.glyph_write && !code_q[7];

  tmcr_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .raddr_i ({rprow, rc[COL_W-1:0]}),
    .rdata_o (ch_rdata)
  );

  tmcr_ram #(.WIDTH(32), .DEPTH(CELLS)) u_fg_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (fg_wdata),
    .raddr_i ({rr[ROW_W-1:0], rc[COL_W-1:0]}),
    .rdata_o (fg_rdata)
  );

  tmcr_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (bg_wdata),
    .raddr_i ({rr[ROW_W-1:0], rc[COL_W-1:0]}),
    .rdata_o (bg_rdata)
  );

  tmcr_ram #(.WIDTH(8), .DEPTH(GLYPH_ROWS)) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (gl_we),
    .waddr_i ({code_q[6:0], gline_q}),
    .wdata_i (gbits_q),
    .raddr_i ({gcode[6:0], v_q[3:0]}),
    .rdata_o (gl_rdata)
  );

  // configuration registers; default colours only seed the reset fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= 8'd80;
      rows_q  <= 7'd25;
      scale_q <= 3'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLS:  cols_q  <= cfg_data_i[7:0];
        CFG_ROWS:  rows_q  <= cfg_data_i[6:0];
        CFG_SCALE: scale_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      rb_q        <= '0;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_write) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (cmd_i.apply_lf) begin
        cursor_q <= cursor_q + {6'd0, nc} - {6'd0, div_r};
      end else if (cmd_i.do_scroll) begin
        cursor_q <= CUR_W'({6'd0, nc} * {8'd0, nr_m1});
        rb_q     <= new_rb;
      end else if (cmd_i.put_write) begin
        cursor_q <= cursor_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      code_q  <= char_code_i;
      col_q   <= cell_col_i;
      row_q   <= cell_row_i;
      fg_q    <= fg_color_i;
      bg_q    <= bg_color_i;
      gbits_q <= glyph_bits_i;
      gline_q <= glyph_line_i;
      px_q    <= pixel_x_i;
      py_q    <= pixel_y_i;
    end
    if (cmd_i.save_rbm) begin
      rbm_q <= div_r[ROW_W-1:0];
    end else if (cmd_i.do_scroll) begin
      rbm_q <= new_rb;
    end
    if (cmd_i.save_u) begin
      u_q <= div_q[11:0];
    end
    if (cmd_i.save_v) begin
      v_q <= div_q[11:0];
    end
    if (cmd_i.do_scroll) begin
      clr_row_q <= ring_row(nr_m1, new_rb, nr);
      clr_col_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_col_q <= clr_col_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      pixel_q <= pix;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.func        = func_q;
    sts_o.is_cr       = code_q == CH_CR;
    sts_o.is_lf       = code_q == CH_LF;
    sts_o.div_done    = div_done;
    sts_o.div_busy    = div_busy;
    sts_o.need_scroll = {1'b0, cursor_q} >= size;
    sts_o.clr_last    = {1'b0, clr_col_q} == (nc - 8'd1);
    sts_o.init_last   = init_cnt_q == CELL_AW'(CELLS - 1);
    sts_o.out_free    = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = pixel_q;

endmodule

FILE: rtl/core/tmcr_ctrl.sv
// controller state machine sequencing the datapath for each transaction
module tmcr_ctrl import tmcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_W_RB  = 4'd3;
  localparam logic [3:0] ST_W_LF  = 4'd4;
  localparam logic [3:0] ST_SCHK  = 4'd5;
  localparam logic [3:0] ST_CLEAR = 4'd6;
  localparam logic [3:0] ST_W_CUR = 4'd7;
  localparam logic [3:0] ST_PUT   = 4'd8;
  localparam logic [3:0] ST_CELL  = 4'd9;
  localparam logic [3:0] ST_W_X   = 4'd10;
  localparam logic [3:0] ST_W_Y   = 4'd11;
  localparam logic [3:0] ST_RD1   = 4'd12;
  localparam logic [3:0] ST_RD2   = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_write = 1'b1;
        if (sts_i.init_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (sts_i.func)
          FUNC_PUT: begin
            if (sts_i.is_cr) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_op    = DIV_RB;
              state_d         = ST_W_RB;
            end
          end
          FUNC_CELL: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_RB;
            state_d         = ST_W_RB;
          end
          FUNC_GLYPH: begin
            cmd_o.glyph_write = 1'b1;
            state_d           = ST_IDLE;
          end
          default: begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_X;
            state_d         = ST_W_X;
          end
        endcase
      end
      ST_W_RB: begin
        if (sts_i.div_done) begin
          cmd_o.save_rbm = 1'b1;
          if (sts_i.func == FUNC_CELL) begin
            state_d = ST_CELL;
          end else if (sts_i.func == FUNC_RENDER) begin
            state_d = ST_RD1;
          end else if (sts_i.is_lf) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_CUR;
            state_d         = ST_W_LF;
          end else begin
            state_d = ST_SCHK;
          end
        end
      end
      ST_W_LF: begin
        if (sts_i.div_done) begin
          cmd_o.apply_lf = 1'b1;
          state_d        = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts_i.need_scroll) begin
          cmd_o.do_scroll = 1'b1;
          state_d         = ST_CLEAR;
        end else if (sts_i.is_lf) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_CUR;
          state_d         = ST_W_CUR;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          if (sts_i.is_lf) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = DIV_CUR;
            state_d         = ST_W_CUR;
          end
        end
      end
      ST_W_CUR: begin
        if (sts_i.div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.put_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_CELL: begin
        cmd_o.cell_write = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_W_X: begin
        if (sts_i.div_done) begin
          cmd_o.save_u    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_Y;
          state_d         = ST_W_Y;
        end
      end
      ST_W_Y: begin
        if (sts_i.div_done) begin
          cmd_o.save_v    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_RB;
          state_d         = ST_W_RB;
        end
      end
      ST_RD1: begin
        state_d = ST_RD2;
      end
      ST_RD2: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

FILE: rtl/core/text_mode_console_renderer_core.sv
// top level of the text-mode console renderer
//
//  channel  direction  handshake           payload
//  in       input      in_valid / stall    func, char_code, cell, colours, glyph, pixel
//  out      output     out_valid / stall   pixel_color
//  cfg      input      cfg_valid / ready   cfg_index, cfg_data
//
//  every transaction but CR and glyph load waits on the shared bit-serial divider (14
//  quotient bits per divide): a cell write divides once, a put or LF twice and a render
//  three times; a scroll adds to either a clear pass over the columns of one row
//  reset: a fill pass writes all 8192 cells before the first transaction
//  stalls: a finished pixel waits in the output register while the next
//  transaction is taken; only the final load of a render waits on out_stall
module text_mode_console_renderer_core import tmcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  cell_col_i,
  input  logic [5:0]  cell_row_i,
  input  logic [31:0] fg_color_i,
  input  logic [31:0] bg_color_i,
  input  logic [7:0]  glyph_bits_i,
  input  logic [3:0]  glyph_line_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_color_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tmcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tmcr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .char_code_i   (char_code_i),
    .cell_col_i    (cell_col_i),
    .cell_row_i    (cell_row_i),
    .fg_color_i    (fg_color_i),
    .bg_color_i    (bg_color_i),
    .glyph_bits_i  (glyph_bits_i),
    .glyph_line_i  (glyph_line_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o)
  );

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.div_busy)
    else $error("divider busy while waiting for a transaction");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken pixel");

  a_one_char_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.init_write, cmd.clr_write, cmd.put_write, cmd.cell_write}))
    else $error("character store written from two sources");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken without processing");

endmodule
